### rtl/imh_pkg.sv
// Package with the item types, command and status codes and sequencer states of the heap core.
package imh_pkg;

  localparam int ID_W      = 10;
  localparam int KEY_W     = 32;
  localparam int KEY_DEPTH = 1024;
  localparam int CNT_OUT_W = 11;

  // Command codes of the input item.
  localparam logic [2:0] CMD_SET_KEY = 3'd0;
  localparam logic [2:0] CMD_APPEND  = 3'd1;
  localparam logic [2:0] CMD_BUILD   = 3'd2;
  localparam logic [2:0] CMD_POP     = 3'd3;
  localparam logic [2:0] CMD_REPLACE = 3'd4;

  // Status codes of the result item.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] key_value;
  } heap_in_t;

  typedef struct packed {
    logic [ID_W-1:0]      top_item;
    logic [KEY_W-1:0]     top_key;
    logic [CNT_OUT_W-1:0] item_count;
    logic [1:0]           status;
  } heap_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_FETCH_ITEM,
    S_KEY_RD,
    S_KEY_LOAD,
    S_SIFT_L,
    S_SIFT_LK,
    S_SIFT_RK,
    S_SIFT_CMP,
    S_ROOT_RD,
    S_ROOT_ITEM,
    S_ROOT_OUT
  } heap_state_t;

endpackage

### rtl/indexed_min_heap_core.sv
// Indexed binary min-heap: key memory, heap slot memory and the sift-down sequencer.
//
// One command is taken at a time; in_stall is high from acceptance until the result item
// has been loaded into the output register, and a pending result does not block the next
// command from being accepted. Set key, append, reserved and failed commands, and a build
// of fewer than two items, go from acceptance to a root slot read and a root key read, and
// then load their result item. Every sift-down level reads the left child slot, the right
// child slot and their two keys in turn through the single read port of each memory. To
// start a sift, pop and build first fetch the moving item and its key, while replace only
// fetches the key of the new item. Build sifts each parent in turn, from the last parent
// to the root. Both memories are left unset by reset, so there is no clearing pass; a key
// must be written before it is used.
module indexed_min_heap_core import imh_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  heap_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output heap_out_t out_item
);

  localparam int AW  = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int CHW = AW + 2;
  localparam int KAW = $clog2(KEY_DEPTH);

  // Memories.
  logic [ID_W-1:0]  heap_mem [MAX_ITEMS];
  logic [KEY_W-1:0] key_mem  [KEY_DEPTH];

  logic            heap_we, heap_re;
  logic [AW-1:0]   heap_wa, heap_ra;
  logic [ID_W-1:0] heap_wd, heap_rd_r;

  logic             key_we, key_re;
  logic [KAW-1:0]   key_wa, key_ra;
  logic [KEY_W-1:0] key_wd, key_rd_r;

  // Sequencer registers.
  heap_state_t      state_r, state_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [ID_W-1:0]  cur_item_r, cur_item_nxt;
  logic [KEY_W-1:0] cur_key_r, cur_key_nxt;
  logic [ID_W-1:0]  litem_r, litem_nxt;
  logic [KEY_W-1:0] lkey_r, lkey_nxt;
  logic [ID_W-1:0]  ritem_r, ritem_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [ID_W-1:0]  root_item_r, root_item_nxt;
  logic             out_valid_r, out_valid_nxt;
  heap_out_t        out_item_r, out_item_nxt;

  logic             accept;
  logic             full, empty;
  logic [CHW-1:0]   left_ix, right_ix, count_ext;
  logic             left_in, right_in;
  logic             pick_left, pick_right;
  logic [KEY_W-1:0] best_key;
  heap_state_t      done_state;
  logic [AW-1:0]    done_idx;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign full      = (count_r == CW'(MAX_ITEMS));
  assign empty     = (count_r == '0);
  assign count_ext = CHW'(count_r);
  assign left_ix   = {1'b0, pos_r, 1'b1};
  assign right_ix  = left_ix + CHW'(1);
  assign left_in   = (left_ix < count_ext);
  assign right_in  = (right_ix < count_ext);

  // Child selection: the left child wins only on a strictly smaller key, then the right.
  assign pick_left  = (cur_key_r > lkey_r);
  assign best_key   = pick_left ? lkey_r : cur_key_r;
  assign pick_right = right_in && (best_key > key_rd_r);

  // Where to go once one sift-down has settled: next parent of a build, else the root.
  always_comb begin
    done_idx = idx_r;
    if ((cmd_r == CMD_BUILD) && (idx_r != '0)) begin
      done_state = S_FETCH;
      done_idx   = idx_r - AW'(1);
    end else begin
      done_state = S_ROOT_RD;
    end
  end

  // Next state, memory controls and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    cur_item_nxt  = cur_item_r;
    cur_key_nxt   = cur_key_r;
    litem_nxt     = litem_r;
    lkey_nxt      = lkey_r;
    ritem_nxt     = ritem_r;
    status_nxt    = status_r;
    root_item_nxt = root_item_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;

    heap_we = 1'b0;
    heap_wa = pos_r;
    heap_wd = cur_item_r;
    heap_re = 1'b0;
    heap_ra = '0;
    key_we  = 1'b0;
    key_wa  = in_item.item_id;
    key_wd  = in_item.key_value;
    key_re  = 1'b0;
    key_ra  = cur_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_item.command;
          status_nxt = STAT_OK;
          state_nxt  = S_ROOT_RD;
          unique case (in_item.command)
            CMD_SET_KEY: begin
              key_we = 1'b1;
            end
            CMD_APPEND: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                heap_we   = 1'b1;
                heap_wa   = AW'(count_r);
                heap_wd   = in_item.item_id;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_BUILD: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else if ((count_r >> 1) != '0) begin
                idx_nxt   = AW'((count_r >> 1) - CW'(1));
                state_nxt = S_FETCH;
              end
            end
            CMD_POP: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
                state_nxt = S_FETCH;
              end
            end
            CMD_REPLACE: begin
              if (empty) begin
                status_nxt = STAT_EMPTY;
              end else begin
                cur_item_nxt = in_item.item_id;
                pos_nxt      = '0;
                state_nxt    = S_KEY_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Read the item that will sift: the last slot for pop, the parent for build.
      S_FETCH: begin
        heap_re = 1'b1;
        if (cmd_r == CMD_POP) begin
          heap_ra = AW'(count_r);
          pos_nxt = '0;
        end else begin
          heap_ra = idx_r;
          pos_nxt = idx_r;
        end
        state_nxt = S_FETCH_ITEM;
      end

      S_FETCH_ITEM: begin
        cur_item_nxt = heap_rd_r;
        state_nxt    = S_KEY_RD;
      end

      S_KEY_RD: begin
        key_re    = 1'b1;
        key_ra    = cur_item_r;
        state_nxt = S_KEY_LOAD;
      end

      S_KEY_LOAD: begin
        cur_key_nxt = key_rd_r;
        state_nxt   = S_SIFT_L;
      end

      // One sift-down level starts with the left child slot, or settles at a leaf.
      S_SIFT_L: begin
        if (left_in) begin
          heap_re   = 1'b1;
          heap_ra   = AW'(left_ix);
          state_nxt = S_SIFT_LK;
        end else begin
          heap_we   = 1'b1;
          state_nxt = done_state;
          idx_nxt   = done_idx;
        end
      end

      S_SIFT_LK: begin
        litem_nxt = heap_rd_r;
        key_re    = 1'b1;
        key_ra    = heap_rd_r;
        heap_re   = 1'b1;
        heap_ra   = AW'(right_ix);
        state_nxt = S_SIFT_RK;
      end

      S_SIFT_RK: begin
        lkey_nxt  = key_rd_r;
        ritem_nxt = heap_rd_r;
        key_re    = 1'b1;
        key_ra    = heap_rd_r;
        state_nxt = S_SIFT_CMP;
      end

      // Move the smaller child up, or drop the moving item in place.
      S_SIFT_CMP: begin
        heap_we = 1'b1;
        if (pick_right) begin
          heap_wd   = ritem_r;
          pos_nxt   = AW'(right_ix);
          state_nxt = S_SIFT_L;
        end else if (pick_left) begin
          heap_wd   = litem_r;
          pos_nxt   = AW'(left_ix);
          state_nxt = S_SIFT_L;
        end else begin
          state_nxt = done_state;
          idx_nxt   = done_idx;
        end
      end

      S_ROOT_RD: begin
        heap_re   = 1'b1;
        heap_ra   = '0;
        state_nxt = S_ROOT_ITEM;
      end

      S_ROOT_ITEM: begin
        root_item_nxt = heap_rd_r;
        key_re        = 1'b1;
        key_ra        = heap_rd_r;
        state_nxt     = S_ROOT_OUT;
      end

      // Load the result item once the output register is free.
      S_ROOT_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.top_item   = empty ? '0 : root_item_r;
          out_item_nxt.top_key    = empty ? '0 : key_rd_r;
          out_item_nxt.item_count = CNT_OUT_W'(count_r);
          out_item_nxt.status     = status_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Heap slot memory with registered read.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    if (heap_re) begin
      heap_rd_r <= heap_mem[heap_ra];
    end
  end

  // Key memory with registered read.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (key_re) begin
      key_rd_r <= key_mem[key_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    cur_item_r  <= cur_item_nxt;
    cur_key_r   <= cur_key_nxt;
    litem_r     <= litem_nxt;
    lkey_r      <= lkey_nxt;
    ritem_r     <= ritem_nxt;
    status_r    <= status_nxt;
    root_item_r <= root_item_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

### sim/indexed_min_heap_core_tb.sv
// Self-checking testbench for the indexed min-heap core: directed rows, random commands, heap fill.
module indexed_min_heap_core_tb import imh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_CAP = 1024;

  // Codes outside the command set; the core must treat them as no-ops.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef struct packed {
    heap_in_t  stim;
    logic      known;
    heap_out_t want;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  heap_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  heap_out_t out_item;

  // Shadow copy of the heap state used to predict each result item.
  logic [KEY_W-1:0] key_mem [KEY_DEPTH];
  logic [ID_W-1:0]  slot_mem [HEAP_CAP];
  bit               key_known [KEY_DEPTH];
  int unsigned      heap_size = 0;

  heap_out_t       pending_results [$];
  directed_row_t   directed_rows [$];
  logic [ID_W-1:0] keyed_ids [$];
  heap_out_t       want_res;
  int              mismatch_count = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;

  indexed_min_heap_core #(.MAX_ITEMS(HEAP_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("indexed_min_heap_core verification failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] slot_key(int unsigned pos);
    return key_mem[slot_mem[pos]];
  endfunction

  // Move the item at pos down, swapping with the smaller child while that child's key is
  // strictly smaller; the left child wins a tie against the right.
  function automatic void sift_down_from(int unsigned pos);
    int unsigned     lc;
    int unsigned     rc;
    int unsigned     best;
    logic [ID_W-1:0] tmp;
    while (1'b1) begin
      lc = 2 * pos + 1;
      rc = lc + 1;
      best = pos;
      if (lc >= heap_size) return;
      if (slot_key(best) > slot_key(lc)) best = lc;
      if (rc < heap_size && slot_key(best) > slot_key(rc)) best = rc;
      if (best == pos) return;
      tmp = slot_mem[pos];
      slot_mem[pos] = slot_mem[best];
      slot_mem[best] = tmp;
      pos = best;
    end
  endfunction

  // Execute one command on the shadow heap and return the result item it should produce.
  function automatic heap_out_t apply_command(heap_in_t stim);
    heap_out_t   res;
    int unsigned idx;
    res = '0;
    res.status = STAT_OK;
    case (stim.command)
      CMD_SET_KEY: begin
        key_mem[stim.item_id] = stim.key_value;
        key_known[stim.item_id] = 1'b1;
      end
      CMD_APPEND: begin
        if (heap_size >= HEAP_CAP) begin
          res.status = STAT_FULL;
        end else begin
          slot_mem[heap_size] = stim.item_id;
          heap_size++;
        end
      end
      CMD_BUILD: begin
        if (heap_size >= HEAP_CAP) begin
          res.status = STAT_FULL;
        end else begin
          for (idx = heap_size / 2; idx > 0; idx--) sift_down_from(idx - 1);
        end
      end
      CMD_POP: begin
        if (heap_size == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          slot_mem[0] = slot_mem[heap_size - 1];
          heap_size--;
          sift_down_from(0);
        end
      end
      CMD_REPLACE: begin
        if (heap_size == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          slot_mem[0] = stim.item_id;
          sift_down_from(0);
        end
      end
      default: begin
      end
    endcase
    if (heap_size > 0) begin
      res.top_item = slot_mem[0];
      res.top_key = slot_key(0);
    end
    res.item_count = CNT_OUT_W'(heap_size);
    return res;
  endfunction

  function automatic void add_row(logic [2:0] cmd, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
                                  logic known, heap_out_t want);
    directed_row_t row;
    row.stim.command = cmd;
    row.stim.item_id = id;
    row.stim.key_value = key;
    row.known = known;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Keys mix small values (many ties), the two extremes and full-range values.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly items whose key is already written, sometimes any item number.
  function automatic logic [ID_W-1:0] pick_id();
    if (keyed_ids.size() != 0 && $urandom_range(0, 9) < 8)
      return keyed_ids[$urandom_range(0, keyed_ids.size() - 1)];
    return ID_W'($urandom_range(0, KEY_DEPTH - 1));
  endfunction

  // Present one item from a falling edge, hold it until accepted, then record its result.
  task automatic send_item(heap_in_t stim, logic known, heap_out_t want);
    heap_out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= stim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (stim.command == CMD_SET_KEY && !key_known[stim.item_id]) keyed_ids.push_back(stim.item_id);
    predicted = apply_command(stim);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  // Hold the input side idle until every outstanding result item has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Random command mix; appends turn into pops once the heap reaches size_cap.
  task automatic random_items(int count, int size_cap);
    heap_in_t stim;
    int       roll;
    repeat (count) begin
      stim.item_id = pick_id();
      stim.key_value = pick_key();
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        stim.command = CMD_SET_KEY;
        stim.item_id = ID_W'($urandom_range(0, KEY_DEPTH - 1));
      end else if (roll < 50) begin
        stim.command = (heap_size >= size_cap) ? CMD_POP : CMD_APPEND;
      end else if (roll < 58) begin
        stim.command = CMD_BUILD;
      end else if (roll < 76) begin
        stim.command = CMD_POP;
      end else if (roll < 94) begin
        stim.command = CMD_REPLACE;
      end else begin
        case ($urandom_range(0, 2))
          0: stim.command = CMD_RSVD_5;
          1: stim.command = CMD_RSVD_6;
          default: stim.command = CMD_RSVD_7;
        endcase
      end
      // An item may enter the heap only once its key has been written.
      if ((stim.command == CMD_APPEND || stim.command == CMD_REPLACE) && !key_known[stim.item_id])
        stim.command = CMD_SET_KEY;
      send_item(stim, 1'b0, '0);
    end
  endtask

  // Fill the heap to one below capacity, build it, then work on the full heap.
  task automatic fill_heap();
    heap_in_t stim;
    int       step;
    while (heap_size < HEAP_CAP - 1) begin
      stim.key_value = pick_key();
      if (keyed_ids.size() == 0 || $urandom_range(0, 9) == 0) begin
        stim.command = CMD_SET_KEY;
        stim.item_id = ID_W'($urandom_range(0, KEY_DEPTH - 1));
      end else begin
        stim.command = CMD_APPEND;
        stim.item_id = keyed_ids[$urandom_range(0, keyed_ids.size() - 1)];
      end
      send_item(stim, 1'b0, '0);
    end
    for (step = 0; step < 30; step++) begin
      stim.item_id = keyed_ids[$urandom_range(0, keyed_ids.size() - 1)];
      stim.key_value = pick_key();
      case (step)
        0: stim.command = CMD_BUILD;
        1, 2: stim.command = CMD_APPEND;
        3: stim.command = CMD_BUILD;
        default: begin
          case ($urandom_range(0, 2))
            0: stim.command = CMD_POP;
            1: stim.command = CMD_REPLACE;
            default: stim.command = CMD_SET_KEY;
          endcase
        end
      endcase
      send_item(stim, 1'b0, '0);
    end
  endtask

  // Receiver stalls at random on each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: top_item %0d top_key %0d count %0d status %0d",
               out_item.top_item, out_item.top_key, out_item.item_count, out_item.status);
        mismatch_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (out_item.top_item !== want_res.top_item) begin
          $error("top_item: expected %0d, got %0d", want_res.top_item, out_item.top_item);
          mismatch_count++;
        end
        if (out_item.top_key !== want_res.top_key) begin
          $error("top_key: expected %0d, got %0d", want_res.top_key, out_item.top_key);
          mismatch_count++;
        end
        if (out_item.item_count !== want_res.item_count) begin
          $error("item_count: expected %0d, got %0d", want_res.item_count, out_item.item_count);
          mismatch_count++;
        end
        if (out_item.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_item.status);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    // Directed rows: empty-heap errors, extremes, no-op codes, ties and a full drain.
    add_row(CMD_POP, 10'd0, 32'd0, 1'b1, {10'd0, 32'd0, 11'd0, STAT_EMPTY});
    add_row(CMD_REPLACE, 10'd1023, 32'hFFFF_FFFF, 1'b1, {10'd0, 32'd0, 11'd0, STAT_EMPTY});
    add_row(CMD_SET_KEY, 10'd0, 32'd0, 1'b1, {10'd0, 32'd0, 11'd0, STAT_OK});
    add_row(CMD_SET_KEY, 10'd1023, 32'hFFFF_FFFF, 1'b1, {10'd0, 32'd0, 11'd0, STAT_OK});
    add_row(CMD_RSVD_5, 10'h2AA, 32'h5555_5555, 1'b1, {10'd0, 32'd0, 11'd0, STAT_OK});
    add_row(CMD_RSVD_6, 10'h155, 32'hAAAA_AAAA, 1'b1, {10'd0, 32'd0, 11'd0, STAT_OK});
    add_row(CMD_RSVD_7, 10'd1023, 32'hFFFF_FFFF, 1'b1, {10'd0, 32'd0, 11'd0, STAT_OK});
    add_row(CMD_BUILD, 10'd0, 32'd0, 1'b1, {10'd0, 32'd0, 11'd0, STAT_OK});
    add_row(CMD_APPEND, 10'd1023, 32'd0, 1'b1, {10'd1023, 32'hFFFF_FFFF, 11'd1, STAT_OK});
    add_row(CMD_SET_KEY, 10'h2AA, 32'h5555_5555, 1'b0, '0);
    add_row(CMD_SET_KEY, 10'h155, 32'hAAAA_AAAA, 1'b0, '0);
    add_row(CMD_APPEND, 10'd0, 32'd0, 1'b0, '0);
    add_row(CMD_APPEND, 10'h2AA, 32'd0, 1'b0, '0);
    add_row(CMD_APPEND, 10'h155, 32'd0, 1'b0, '0);
    add_row(CMD_BUILD, 10'd0, 32'd0, 1'b0, '0);
    add_row(CMD_SET_KEY, 10'd5, 32'h5555_5555, 1'b0, '0);
    add_row(CMD_APPEND, 10'd5, 32'd0, 1'b0, '0);
    add_row(CMD_BUILD, 10'd0, 32'd0, 1'b0, '0);
    add_row(CMD_REPLACE, 10'd1023, 32'd0, 1'b0, '0);
    repeat (5) add_row(CMD_POP, 10'd0, 32'd0, 1'b0, '0);
    add_row(CMD_POP, 10'd0, 32'd0, 1'b1, {10'd0, 32'd0, 11'd0, STAT_EMPTY});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].want);
    wait_drained();

    // Random phases, one per idling pattern, each ending with the input side drained.
    send_idle_pct = 0;
    stall_pct = 0;
    random_items(190, 6);
    wait_drained();
    send_idle_pct = 57;
    stall_pct = 0;
    random_items(190, 40);
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 57;
    random_items(190, 120);
    wait_drained();
    send_idle_pct = 11;
    stall_pct = 11;
    random_items(190, 24);
    wait_drained();
    fill_heap();
    wait_drained();

    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("indexed_min_heap_core verification clean");
    end else begin
      $display("indexed_min_heap_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/imh_pkg.sv
rtl/indexed_min_heap_core.sv
sim/indexed_min_heap_core_tb.sv
